// ===== design/psrrd_pkg.sv =====
// ----------------------------------------------------------------------------
// psrrd_pkg: shared types for the process slot round-robin dispatcher
// Command and response beats, operation and status codes, default sizing.
// ----------------------------------------------------------------------------
package psrrd_pkg;

	localparam int SLOT_W        = 4;
	localparam int DEFAULT_SLOTS = 16;

	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_READY = 2'd1,
		FN_YIELD = 2'd2,
		FN_STOP  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_FREE     = 2'd1,
		ST_QUEUE_EMPTY = 2'd2,
		ST_NOT_ALLOC   = 2'd3
	} status_t;

	typedef struct packed {
		func_t             func;
		logic [SLOT_W-1:0] slot_id;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] granted_slot;
		logic [SLOT_W-1:0] running_slot;
		logic              running_valid;
	} rsp_t;

endpackage

// ===== design/process_slot_round_robin_dispatcher.sv =====
// ----------------------------------------------------------------------------
// process_slot_round_robin_dispatcher: round-robin process slot dispatcher
// Free list, FIFO ready queue and one running slot over a fixed slot table.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid / cmd_stall / cmd) carries one operation per
//   beat: allocate, make a slot ready, yield, or stop the running slot.
//   Response channel (rsp_valid / rsp_stall / rsp) returns exactly one beat
//   per command with status, granted slot and the slot now running.
//   A command beat passes the command register, then the response register,
//   before response valid. One command per cycle is sustained while the
//   response is not stalled; all list work is head/tail pointer updates,
//   and the link table's registered read of each list's next head is issued
//   the cycle a head moves, so it is ready for the following command.
//   After reset every slot is free, the free list runs from the highest slot
//   down to slot 0, the ready queue is empty and nothing runs. No clearing
//   pass is needed; commands are taken right after reset.
//   When the receiver stalls, the response holds; a command already
//   registered waits and cmd_stall rises until the response is taken.
// ----------------------------------------------------------------------------
module process_slot_round_robin_dispatcher import psrrd_pkg::*; #(
	parameter int SLOTS = DEFAULT_SLOTS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int XW = ((IW > SLOT_W) ? IW : SLOT_W) + 1;

	function automatic logic [SLOT_W-1:0] to_port(input logic [IW-1:0] v);
		logic [XW-1:0] t;
		t = XW'(v);
		return t[SLOT_W-1:0];
	endfunction

	// command register
	logic          vld_s1;
	cmd_t          cmd_s1;
	// list state
	logic [IW-1:0] free_head_q, free_tail_q, ready_head_q, ready_tail_q, cur_q;
	logic          free_empty_q, ready_empty_q, cur_vld_q;
	logic [SLOTS-1:0] alloc_q;
	// pending link overrides for each list head
	logic          ovr_f_q, ovr_r_q;
	logic [IW-1:0] ovr_f_d_q, ovr_r_d_q;
	// response register
	logic          rsp_vld_q;
	rsp_t          rsp_q;

	logic          go;
	logic [IW-1:0] rd_f, rd_r, free_nxt, ready_nxt;
	logic          we;
	logic [IW-1:0] waddr, wdata;
	logic [IW-1:0] n_free_head, n_free_tail, n_ready_head, n_ready_tail, n_cur;
	logic          n_free_empty, n_ready_empty, n_cur_vld;
	logic [SLOTS-1:0] n_alloc;
	logic          f_adv, f_set, r_adv, r_set;
	status_t       status;
	logic [IW-1:0] granted;
	logic [XW-1:0] sid_x;
	logic [IW-1:0] sid_i;
	logic          sid_ok;

	assign go        = vld_s1 && !(rsp_vld_q && rsp_stall);
	assign cmd_stall = vld_s1 && rsp_vld_q && rsp_stall;

	assign free_nxt  = ovr_f_q ? ovr_f_d_q : rd_f;
	assign ready_nxt = ovr_r_q ? ovr_r_d_q : rd_r;

	assign sid_x  = XW'(cmd_s1.slot_id);
	assign sid_i  = sid_x[IW-1:0];
	assign sid_ok = (sid_x < XW'(SLOTS)) && alloc_q[sid_i];

	psrrd_link_mem #(.SLOTS(SLOTS)) u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (go && we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re_a    (go && f_adv),
		.raddr_a (n_free_head),
		.rdata_a (rd_f),
		.re_b    (go && r_adv),
		.raddr_b (n_ready_head),
		.rdata_b (rd_r)
	);

	// execute one command against the lists
	always_comb begin
		n_free_head   = free_head_q;
		n_free_tail   = free_tail_q;
		n_free_empty  = free_empty_q;
		n_ready_head  = ready_head_q;
		n_ready_tail  = ready_tail_q;
		n_ready_empty = ready_empty_q;
		n_cur         = cur_q;
		n_cur_vld     = cur_vld_q;
		n_alloc       = alloc_q;
		we            = 1'b0;
		waddr         = '0;
		wdata         = '0;
		f_adv         = 1'b0;
		f_set         = 1'b0;
		r_adv         = 1'b0;
		r_set         = 1'b0;
		status        = ST_OK;
		granted       = '0;
		case (cmd_s1.func)
			FN_ALLOC: begin
				if (free_empty_q) begin
					status = ST_NO_FREE;
				end else begin
					if (free_head_q == free_tail_q) begin
						n_free_empty = 1'b1;
					end else begin
						n_free_head = free_nxt;
						f_adv       = 1'b1;
					end
					n_alloc[free_head_q] = 1'b1;
					granted              = free_head_q;
				end
			end
			FN_READY: begin
				if (!sid_ok) begin
					status = ST_NOT_ALLOC;
				end else begin
					n_alloc[sid_i] = 1'b0;
					if (ready_empty_q) begin
						n_ready_head  = sid_i;
						n_ready_empty = 1'b0;
						r_set         = 1'b1;
					end else begin
						we    = 1'b1;
						waddr = ready_tail_q;
						wdata = sid_i;
					end
					n_ready_tail = sid_i;
				end
			end
			default: begin
				// requeue or free the running slot
				if (cur_vld_q) begin
					if (cmd_s1.func == FN_YIELD) begin
						if (ready_empty_q) begin
							n_ready_head  = cur_q;
							n_ready_empty = 1'b0;
							r_set         = 1'b1;
						end else begin
							we    = 1'b1;
							waddr = ready_tail_q;
							wdata = cur_q;
						end
						n_ready_tail = cur_q;
					end else begin
						if (free_empty_q) begin
							n_free_head  = cur_q;
							n_free_empty = 1'b0;
							f_set        = 1'b1;
						end else begin
							we    = 1'b1;
							waddr = free_tail_q;
							wdata = cur_q;
						end
						n_free_tail = cur_q;
					end
				end
				// dispatch the ready head
				if (n_ready_empty) begin
					status    = ST_QUEUE_EMPTY;
					n_cur_vld = 1'b0;
				end else begin
					n_cur     = n_ready_head;
					n_cur_vld = 1'b1;
					if (n_ready_head == n_ready_tail) begin
						n_ready_empty = 1'b1;
					end else begin
						n_ready_head = (we && waddr == ready_head_q) ? wdata : ready_nxt;
						r_adv        = 1'b1;
						r_set        = 1'b0;
					end
				end
			end
		endcase
	end

	// command register: load when not held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	// commit list state and head overrides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q   <= IW'(SLOTS - 1);
			free_tail_q   <= '0;
			free_empty_q  <= 1'b0;
			ready_head_q  <= '0;
			ready_tail_q  <= '0;
			ready_empty_q <= 1'b1;
			cur_q         <= '0;
			cur_vld_q     <= 1'b0;
			alloc_q       <= '0;
			ovr_f_q       <= 1'b1;
			ovr_f_d_q     <= IW'(SLOTS - 2);
			ovr_r_q       <= 1'b0;
			ovr_r_d_q     <= '0;
		end else if (go) begin
			free_head_q   <= n_free_head;
			free_tail_q   <= n_free_tail;
			free_empty_q  <= n_free_empty;
			ready_head_q  <= n_ready_head;
			ready_tail_q  <= n_ready_tail;
			ready_empty_q <= n_ready_empty;
			cur_q         <= n_cur;
			cur_vld_q     <= n_cur_vld;
			alloc_q       <= n_alloc;
			// free head link
			if (f_adv) begin
				ovr_f_q   <= we && (waddr == n_free_head);
				ovr_f_d_q <= wdata;
			end else if (f_set) begin
				ovr_f_q <= 1'b0;
			end else if (we && waddr == free_head_q) begin
				ovr_f_q   <= 1'b1;
				ovr_f_d_q <= wdata;
			end
			// ready head link
			if (r_adv) begin
				ovr_r_q   <= we && (waddr == n_ready_head);
				ovr_r_d_q <= wdata;
			end else if (r_set) begin
				ovr_r_q <= 1'b0;
			end else if (we && waddr == ready_head_q) begin
				ovr_r_q   <= 1'b1;
				ovr_r_d_q <= wdata;
			end
		end
	end

	// response register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (go) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_q.status        <= status;
			rsp_q.granted_slot  <= to_port(granted);
			rsp_q.running_slot  <= n_cur_vld ? to_port(n_cur) : '0;
			rsp_q.running_valid <= n_cur_vld;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/psrrd_link_mem.sv =====
// ----------------------------------------------------------------------------
// psrrd_link_mem: slot link table
// One write port, two registered read ports. Entries never written since
// reset read as their reset link (slot i points to slot i-1, slot 0 to 0).
// ----------------------------------------------------------------------------
module psrrd_link_mem import psrrd_pkg::*; #(
	parameter int SLOTS = DEFAULT_SLOTS,
	localparam int IW = $clog2(SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [IW-1:0] wdata,
	input  logic          re_a,
	input  logic [IW-1:0] raddr_a,
	output logic [IW-1:0] rdata_a,
	input  logic          re_b,
	input  logic [IW-1:0] raddr_b,
	output logic [IW-1:0] rdata_b
);

	logic [IW-1:0]    mem [SLOTS];
	logic [SLOTS-1:0] written_q;
	logic [IW-1:0]    rd_a_q, rd_b_q;
	logic [IW-1:0]    ra_a_q, ra_b_q;
	logic             rv_a_q, rv_b_q;

	function automatic logic [IW-1:0] reset_link(input logic [IW-1:0] idx);
		return (idx == '0) ? '0 : idx - IW'(1);
	endfunction

	// write and read the table
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rd_a_q <= mem[raddr_a];
			ra_a_q <= raddr_a;
		end
		if (re_b) begin
			rd_b_q <= mem[raddr_b];
			ra_b_q <= raddr_b;
		end
	end

	// track written entries, sample them with each read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rv_a_q    <= 1'b0;
			rv_b_q    <= 1'b0;
		end else begin
			if (re_a) begin
				rv_a_q <= written_q[raddr_a];
			end
			if (re_b) begin
				rv_b_q <= written_q[raddr_b];
			end
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
		end
	end

	// fall back to the reset link for untouched entries
	assign rdata_a = rv_a_q ? rd_a_q : reset_link(ra_a_q);
	assign rdata_b = rv_b_q ? rd_b_q : reset_link(ra_b_q);

endmodule

// ===== design/psrrd_checker.sv =====
// ----------------------------------------------------------------------------
// psrrd_checker: port-level checks for the dispatcher
// Watches both channels and the response fields over time.
// ----------------------------------------------------------------------------
module psrrd_checker import psrrd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// command backpressure only comes from a stalled response
	a_cmd_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> rsp_valid && rsp_stall)
		else $error("command stalled without response backpressure");

	// idle dispatcher reports slot zero
	a_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.running_valid |-> rsp.running_slot == '0)
		else $error("running slot nonzero with nothing running");

	// a failed dispatch leaves nothing running
	a_empty_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_QUEUE_EMPTY |-> !rsp.running_valid)
		else $error("slot running after empty ready queue");

	// only a successful allocate grants a nonzero slot
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.granted_slot != '0 |-> rsp.status == ST_OK)
		else $error("slot granted with error status");

endmodule

bind process_slot_round_robin_dispatcher psrrd_checker u_psrrd_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: process_slot_round_robin_dispatcher check
// Runs a directed table of commands from reset (empty queues, full free list,
// requeue of a lone running slot, bad ready requests), then random command
// streams that mostly pick allocated slots for ready requests. Each response
// beat is checked per field against a typed row's want or a behavioral copy
// of the slot lists kept here, in phases: no idling, gaps, stalls and both.
// ----------------------------------------------------------------------------
module testbench;
	import psrrd_pkg::*;

	localparam int N_SLOTS  = DEFAULT_SLOTS;
	localparam int N_DIR    = 23;
	localparam int N_RANDOM = 355;

	typedef enum logic [1:0] {
		SS_FREE  = 2'd0,
		SS_ALLOC = 2'd1,
		SS_READY = 2'd2,
		SS_RUN   = 2'd3
	} slot_state_t;

	// one row of the directed plan; want is used only when typed is set
	typedef struct {
		func_t             func;
		logic [SLOT_W-1:0] slot_id;
		int                reps;
		bit                typed;
		rsp_t              want;
	} plan_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	cmd_t cmd       = '0;
	logic rsp_stall = 1'b0;
	logic cmd_stall;
	logic rsp_valid;
	rsp_t rsp;

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   mismatch_count = 0;
	rsp_t pending_rsp[$];

	// slot list state mirrored for prediction
	logic [SLOT_W-1:0] link_tbl [N_SLOTS];
	slot_state_t       slot_state [N_SLOTS];
	logic [SLOT_W-1:0] free_hd, free_tl, rdy_hd, rdy_tl, run_slot;
	logic              free_none, rdy_none, run_on;

	plan_row_t plan [N_DIR] = '{
		'{FN_YIELD, 4'd0,  1,  1'b1, '{ST_QUEUE_EMPTY, 4'd0,  4'd0,  1'b0}},
		'{FN_STOP,  4'd0,  1,  1'b1, '{ST_QUEUE_EMPTY, 4'd0,  4'd0,  1'b0}},
		'{FN_READY, 4'd5,  1,  1'b1, '{ST_NOT_ALLOC,   4'd0,  4'd0,  1'b0}},
		'{FN_ALLOC, 4'd0,  1,  1'b1, '{ST_OK,          4'd15, 4'd0,  1'b0}},
		'{FN_ALLOC, 4'd0,  1,  1'b1, '{ST_OK,          4'd14, 4'd0,  1'b0}},
		'{FN_READY, 4'd15, 1,  1'b1, '{ST_OK,          4'd0,  4'd0,  1'b0}},
		'{FN_READY, 4'd15, 1,  1'b1, '{ST_NOT_ALLOC,   4'd0,  4'd0,  1'b0}},
		'{FN_YIELD, 4'd0,  1,  1'b1, '{ST_OK,          4'd0,  4'd15, 1'b1}},
		'{FN_READY, 4'd15, 1,  1'b1, '{ST_NOT_ALLOC,   4'd0,  4'd15, 1'b1}},
		'{FN_YIELD, 4'd0,  1,  1'b1, '{ST_OK,          4'd0,  4'd15, 1'b1}},
		'{FN_READY, 4'd14, 1,  1'b1, '{ST_OK,          4'd0,  4'd15, 1'b1}},
		'{FN_YIELD, 4'd0,  1,  1'b0, '0},
		'{FN_YIELD, 4'd0,  1,  1'b0, '0},
		'{FN_STOP,  4'd0,  1,  1'b0, '0},
		'{FN_STOP,  4'd0,  1,  1'b1, '{ST_QUEUE_EMPTY, 4'd0,  4'd0,  1'b0}},
		'{FN_ALLOC, 4'd0,  16, 1'b0, '0},
		'{FN_ALLOC, 4'd0,  1,  1'b1, '{ST_NO_FREE,     4'd0,  4'd0,  1'b0}},
		'{FN_READY, 4'd0,  1,  1'b0, '0},
		'{FN_READY, 4'd15, 1,  1'b0, '0},
		'{FN_YIELD, 4'd0,  1,  1'b0, '0},
		'{FN_STOP,  4'd0,  1,  1'b0, '0},
		'{FN_ALLOC, 4'd0,  1,  1'b1, '{ST_OK,          4'd0,  4'd15, 1'b1}},
		'{FN_STOP,  4'd0,  1,  1'b1, '{ST_QUEUE_EMPTY, 4'd0,  4'd0,  1'b0}}
	};

	process_slot_round_robin_dispatcher #(.SLOTS(N_SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ---- slot list predictor ----

	function automatic void clear_slots();
		for (int i = 0; i < N_SLOTS; i++) begin
			link_tbl[i]   = (i == 0) ? '0 : SLOT_W'(i - 1);
			slot_state[i] = SS_FREE;
		end
		free_hd   = SLOT_W'(N_SLOTS - 1);
		free_tl   = '0;
		free_none = 1'b0;
		rdy_hd    = '0;
		rdy_tl    = '0;
		rdy_none  = 1'b1;
		run_slot  = '0;
		run_on    = 1'b0;
	endfunction

	function automatic void queue_ready(logic [SLOT_W-1:0] s);
		slot_state[s] = SS_READY;
		if (rdy_none) begin
			rdy_hd   = s;
			rdy_none = 1'b0;
		end else begin
			link_tbl[rdy_tl] = s;
		end
		rdy_tl = s;
	endfunction

	function automatic void return_free(logic [SLOT_W-1:0] s);
		slot_state[s] = SS_FREE;
		if (free_none) begin
			free_hd   = s;
			free_none = 1'b0;
		end else begin
			link_tbl[free_tl] = s;
		end
		free_tl = s;
	endfunction

	// move the ready head onto the processor; false when the queue is empty
	function automatic logic run_next();
		logic [SLOT_W-1:0] s;
		if (rdy_none) begin
			run_on = 1'b0;
			return 1'b0;
		end
		s = rdy_hd;
		if (rdy_hd == rdy_tl)
			rdy_none = 1'b1;
		else
			rdy_hd = link_tbl[s];
		slot_state[s] = SS_RUN;
		run_slot      = s;
		run_on        = 1'b1;
		return 1'b1;
	endfunction

	function automatic rsp_t dispatch_step(cmd_t c);
		rsp_t              r;
		logic [SLOT_W-1:0] s;
		r.status       = ST_OK;
		r.granted_slot = '0;
		case (c.func)
			FN_ALLOC: begin
				if (free_none) begin
					r.status = ST_NO_FREE;
				end else begin
					s = free_hd;
					if (free_hd == free_tl)
						free_none = 1'b1;
					else
						free_hd = link_tbl[s];
					slot_state[s]  = SS_ALLOC;
					r.granted_slot = s;
				end
			end
			FN_READY: begin
				if (c.slot_id >= N_SLOTS || slot_state[c.slot_id] != SS_ALLOC)
					r.status = ST_NOT_ALLOC;
				else
					queue_ready(c.slot_id);
			end
			FN_YIELD: begin
				if (run_on) begin
					run_on = 1'b0;
					queue_ready(run_slot);
				end
				if (!run_next())
					r.status = ST_QUEUE_EMPTY;
			end
			default: begin
				if (run_on) begin
					run_on = 1'b0;
					return_free(run_slot);
				end
				if (!run_next())
					r.status = ST_QUEUE_EMPTY;
			end
		endcase
		r.running_slot  = run_on ? run_slot : '0;
		r.running_valid = run_on;
		return r;
	endfunction

	// ---- command side ----

	// drive one beat, hold it through stalls, record the expected response
	task automatic send_cmd(cmd_t c, bit typed, rsp_t want);
		rsp_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		predicted = dispatch_step(c);
		pending_rsp.push_back(typed ? want : predicted);
	endtask

	// drop valid and wait until every expected response has arrived
	task automatic drain_responses();
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// mostly an allocated slot, sometimes any slot
	function automatic logic [SLOT_W-1:0] pick_ready_slot();
		logic [SLOT_W-1:0] owned[$];
		for (int i = 0; i < N_SLOTS; i++)
			if (slot_state[i] == SS_ALLOC)
				owned.push_back(SLOT_W'(i));
		if (owned.size() == 0 || $urandom_range(99) < 25)
			return SLOT_W'($urandom_range(N_SLOTS - 1));
		return owned[$urandom_range(owned.size() - 1)];
	endfunction

	task automatic send_random(int count);
		cmd_t c;
		int   alloc_w;
		int   pick;
		alloc_w = 40;
		for (int n = 0; n < count; n++) begin
			// shift the allocate share now and then to reach full and empty lists
			if (n % 50 == 0)
				alloc_w = ($urandom_range(2) == 0) ? 10 : ($urandom_range(1) ? 40 : 70);
			pick = $urandom_range(99);
			c.slot_id = SLOT_W'($urandom_range(N_SLOTS - 1));
			if (pick < alloc_w) begin
				c.func = FN_ALLOC;
			end else begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					c.func    = FN_READY;
					c.slot_id = pick_ready_slot();
				end else if (pick < 75) begin
					c.func = FN_YIELD;
				end else begin
					c.func = FN_STOP;
				end
			end
			send_cmd(c, 1'b0, '0);
		end
	endtask

	// ---- response side ----

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	initial begin
		rsp_t want;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected response beat: expected none, actual %0d %0d %0d %0d",
						$time, rsp.status, rsp.granted_slot, rsp.running_slot, rsp.running_valid);
					mismatch_count++;
				end else begin
					want = pending_rsp.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("granted_slot", want.granted_slot, rsp.granted_slot);
					check_field("running_slot", want.running_slot, rsp.running_slot);
					check_field("running_valid", want.running_valid, rsp.running_valid);
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// ---- run control ----

	initial begin
		cmd_t c;
		clear_slots();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			if (phase == 0) begin
				foreach (plan[i]) begin
					c.func    = plan[i].func;
					c.slot_id = plan[i].slot_id;
					repeat (plan[i].reps)
						send_cmd(c, plan[i].typed, plan[i].want);
				end
			end
			send_random(N_RANDOM);
			drain_responses();
		end
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("process_slot_round_robin_dispatcher test passed");
		else
			$display("process_slot_round_robin_dispatcher test failed");
		$finish;
	end

	// end a hung run
	initial begin
		#2_000_000;
		$display("process_slot_round_robin_dispatcher test failed");
		$finish;
	end

endmodule
